// File: rtl/core/mfr_pkg.sv
package mfr_pkg;

	localparam int TAP_COUNT = 6;
	localparam int TAPS_PER_WORD = 3;
	localparam int DELAY_W = 15;
	localparam int WEIGHT_W = 16;
	localparam int SAMPLE_W = 16;
	localparam int CFG_DATA_W = 48;
	localparam int CFG_INDEX_W = 3;

	typedef logic [2:0] tap_idx_t;

	localparam tap_idx_t TAP_LAST = tap_idx_t'(TAP_COUNT - 1);
	localparam tap_idx_t TAP_DONE = tap_idx_t'(TAP_COUNT);

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_VOLUME      = 3'd0,
		REG_LP_KEEP     = 3'd1,
		REG_LP_NEW      = 3'd2,
		REG_DELAYS_LO   = 3'd3,
		REG_DELAYS_HI   = 3'd4,
		REG_WEIGHTS_LO  = 3'd5,
		REG_WEIGHTS_HI  = 3'd6
	} reg_index_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TAPS,
		ST_FILTER,
		ST_OUTPUT,
		ST_MIX,
		ST_SCALE,
		ST_WRITE
	} mfr_state_t;

endpackage

// File: rtl/core/mfr_ram.sv
module mfr_ram
	#(
		parameter int WIDTH = 16,
		parameter int DEPTH = 32768
	)
	(
		input  logic                     clk,
		input  logic                     we,
		input  logic [$clog2(DEPTH)-1:0] waddr,
		input  logic [WIDTH-1:0]         wdata,
		input  logic [$clog2(DEPTH)-1:0] raddr,
		output logic [WIDTH-1:0]         rdata
	);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/core/multitap_feedback_reverb.sv
// Channel       Direction  Payload
// s_axis        in         tdata[15:0] left_sample, tdata[31:16] right_sample
// m_axis        out        tdata[15:0] wet_sample
// cfg           in         cfg_we, cfg_index, cfg_data (write only)
//
// A frame passes through an accept state, then six tap reads stream through the single
// ring read port and the weight multiplier, followed by the low-pass, mix, volume scale
// and write-back states.
// Reset clears the write index, the ring fill flag and the low-pass state; the ring
// itself is not swept, cells beyond the fill point read as zero.
// A held result stalls the next frame only at the point where it would be loaded.
module multitap_feedback_reverb
	import mfr_pkg::*;
	#(
		parameter int RING_DEPTH = 32768
	)
	(
		input  logic                   clk,
		input  logic                   arst_n,
		input  logic                   s_axis_tvalid,
		output logic                   s_axis_tready,
		input  logic [31:0]            s_axis_tdata,   // left_sample, right_sample
		output logic                   m_axis_tvalid,
		input  logic                   m_axis_tready,
		output logic [15:0]            m_axis_tdata,   // wet_sample
		input  logic                   cfg_we,
		input  logic [CFG_INDEX_W-1:0] cfg_index,
		input  logic [CFG_DATA_W-1:0]  cfg_data
	);

	localparam int AW = $clog2(RING_DEPTH);
	localparam int MOD_STEPS = 16 - AW;
	localparam logic [AW:0] DEPTH_EXT = (AW+1)'(RING_DEPTH);
	localparam logic [AW-1:0] LAST_ADDR = AW'(RING_DEPTH - 1);

	function automatic logic [AW-1:0] reduce_delay(input logic [DELAY_W-1:0] d);
		logic [15:0] r;
		r = {1'b0, d};
		for (int i = MOD_STEPS - 1; i >= 0; i--) begin
			if (r >= 16'(RING_DEPTH << i)) begin
				r = r - 16'(RING_DEPTH << i);
			end
		end
		return r[AW-1:0];
	endfunction

	function automatic logic signed [15:0] sat_17(input logic signed [16:0] v);
		if (v > 17'sd32767) begin
			return 16'sh7fff;
		end else if (v < -17'sd32768) begin
			return 16'sh8000;
		end else begin
			return v[15:0];
		end
	endfunction

	function automatic logic signed [15:0] sat_20(input logic signed [19:0] v);
		if (v > 20'sd32767) begin
			return 16'sh7fff;
		end else if (v < -20'sd32768) begin
			return 16'sh8000;
		end else begin
			return v[15:0];
		end
	endfunction

	// configuration
	logic signed [15:0] volume_q;
	logic [14:0]        lp_keep_q;
	logic [14:0]        lp_new_q;
	logic [44:0]        delays_lo_q;
	logic [44:0]        delays_hi_q;
	logic [47:0]        weights_lo_q;
	logic [47:0]        weights_hi_q;

	// control
	mfr_state_t  state_q, state_d;
	tap_idx_t    iss_q;
	logic [AW-1:0] widx_q;
	logic        full_q;
	logic        out_valid_q;
	logic        v_s1, v_s2, v_s3;
	tap_idx_t    k_s1, k_s2, k_s3;
	logic        live_s2;
	logic [AW-1:0] dm_s1;

	// datapath
	logic signed [15:0] left_q, right_q;
	logic signed [15:0] z_q;
	logic signed [15:0] wet_q;
	logic signed [31:0] prod_s3;
	logic signed [31:0] acc_q;
	logic signed [31:0] pk_q, pn_q, pa_q;
	logic signed [15:0] a_q, bsel_q;

	logic               accept;
	logic               issue;
	logic               load_out;
	logic               ram_we;
	logic [AW-1:0]      raddr;
	logic [AW:0]        ra_diff, ra_wrap;
	logic [15:0]        ram_rdata;
	logic [15:0]        cell_wdata;
	logic [DELAY_W-1:0] delay_sel;
	logic signed [15:0] weight_sel;
	logic signed [15:0] cell_sel;
	logic signed [15:0] tap_sat;
	logic signed [32:0] lp_sum;
	logic signed [32:0] cell_diff;
	logic signed [15:0] mix_zl, mix_a, mix_b;

	always_comb begin
		case (iss_q)
			3'd0: delay_sel = delays_lo_q[14:0];
			3'd1: delay_sel = delays_lo_q[29:15];
			3'd2: delay_sel = delays_lo_q[44:30];
			3'd3: delay_sel = delays_hi_q[14:0];
			3'd4: delay_sel = delays_hi_q[29:15];
			3'd5: delay_sel = delays_hi_q[44:30];
			default: delay_sel = '0;
		endcase
	end

	always_comb begin
		case (k_s2)
			3'd0: weight_sel = weights_lo_q[15:0];
			3'd1: weight_sel = weights_lo_q[31:16];
			3'd2: weight_sel = weights_lo_q[47:32];
			3'd3: weight_sel = weights_hi_q[15:0];
			3'd4: weight_sel = weights_hi_q[31:16];
			3'd5: weight_sel = weights_hi_q[47:32];
			default: weight_sel = '0;
		endcase
	end

	assign ra_diff = {1'b0, widx_q} - {1'b0, dm_s1};
	assign ra_wrap = ra_diff[AW] ? ra_diff + DEPTH_EXT : ra_diff;
	assign raddr = ra_wrap[AW-1:0];

	assign cell_sel = live_s2 ? $signed(ram_rdata) : 16'sd0;
	assign tap_sat = sat_20(acc_q[31:12]);
	assign lp_sum = {pk_q[31], pk_q} + {pn_q[31], pn_q};
	assign mix_zl = sat_17({z_q[15], z_q} + {left_q[15], left_q});
	assign mix_a = sat_17({mix_zl[15], mix_zl} + {right_q[15], right_q});
	assign mix_b = sat_17({z_q[15], z_q} + {right_q[15], right_q});
	assign cell_diff = {pa_q[31], pa_q} - {{17{bsel_q[15]}}, bsel_q};
	assign cell_wdata = cell_diff[30:15];

	assign accept = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = wet_q;

	always_comb begin
		state_d = state_q;
		s_axis_tready = 1'b0;
		issue = 1'b0;
		load_out = 1'b0;
		ram_we = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					state_d = ST_TAPS;
				end
			end
			ST_TAPS: begin
				issue = (iss_q != TAP_DONE);
				if (v_s3 && k_s3 == TAP_LAST) begin
					state_d = ST_FILTER;
				end
			end
			ST_FILTER: begin
				state_d = ST_OUTPUT;
			end
			ST_OUTPUT: begin
				if (!out_valid_q || m_axis_tready) begin
					load_out = 1'b1;
					state_d = ST_MIX;
				end
			end
			ST_MIX: begin
				state_d = ST_SCALE;
			end
			ST_SCALE: begin
				state_d = ST_WRITE;
			end
			ST_WRITE: begin
				ram_we = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			volume_q <= '0;
			lp_keep_q <= '0;
			lp_new_q <= '0;
			delays_lo_q <= '0;
			delays_hi_q <= '0;
			weights_lo_q <= '0;
			weights_hi_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_VOLUME:     volume_q <= cfg_data[15:0];
				REG_LP_KEEP:    lp_keep_q <= cfg_data[14:0];
				REG_LP_NEW:     lp_new_q <= cfg_data[14:0];
				REG_DELAYS_LO:  delays_lo_q <= cfg_data[44:0];
				REG_DELAYS_HI:  delays_hi_q <= cfg_data[44:0];
				REG_WEIGHTS_LO: weights_lo_q <= cfg_data[47:0];
				REG_WEIGHTS_HI: weights_hi_q <= cfg_data[47:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iss_q <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			widx_q <= '0;
			full_q <= 1'b0;
			out_valid_q <= 1'b0;
			z_q <= '0;
		end else begin
			if (accept) begin
				iss_q <= '0;
			end else if (issue) begin
				iss_q <= iss_q + 3'd1;
			end
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (ram_we) begin
				widx_q <= (widx_q == LAST_ADDR) ? '0 : widx_q + 1'b1;
				if (widx_q == LAST_ADDR) begin
					full_q <= 1'b1;
				end
			end
			if (load_out) begin
				z_q <= lp_sum[30:15];
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// tap pipeline and arithmetic
	always_ff @(posedge clk) begin
		if (accept) begin
			left_q <= s_axis_tdata[15:0];
			right_q <= s_axis_tdata[31:16];
			pk_q <= z_q * $signed({1'b0, lp_keep_q});
		end
		dm_s1 <= reduce_delay(delay_sel);
		k_s1 <= iss_q;
		k_s2 <= k_s1;
		live_s2 <= full_q || (raddr < widx_q);
		k_s3 <= k_s2;
		prod_s3 <= cell_sel * weight_sel;
		if (accept) begin
			acc_q <= '0;
		end else if (v_s3) begin
			acc_q <= acc_q + prod_s3;
		end
		if (state_q == ST_FILTER) begin
			pn_q <= tap_sat * $signed({1'b0, lp_new_q});
		end
		if (load_out) begin
			wet_q <= lp_sum[30:15];
		end
		if (state_q == ST_MIX) begin
			a_q <= mix_a;
			bsel_q <= volume_q[15] ? mix_b : 16'sd0;
		end
		if (state_q == ST_SCALE) begin
			pa_q <= a_q * volume_q;
		end
	end

	mfr_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (RING_DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (ram_we),
		.waddr (widx_q),
		.wdata (cell_wdata),
		.raddr (raddr),
		.rdata (ram_rdata)
	);

`ifndef NO_ASSERTIONS
	a_write_after_taps: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> !(v_s1 || v_s2 || v_s3))
		else $error("ring write while tap reads are in flight");

	a_accept_pipe_empty: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> !(v_s1 || v_s2 || v_s3))
		else $error("frame accepted with tap pipeline busy");

	a_widx_step: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |=> (widx_q == '0) || (widx_q == $past(widx_q) + 1'b1))
		else $error("write index did not advance by one");

	a_full_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		full_q |=> full_q)
		else $error("ring fill flag dropped");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> !out_valid_q || m_axis_tready)
		else $error("result register overwritten while held");
`endif

endmodule
